/* hw/rtl/svpwm_pkg.sv */
package svpwm_pkg;

	localparam int COUNT_BITS = 16;
	localparam int PH_W       = 34;
	localparam int V_W        = 33;
	localparam int MUL_A_W    = 35;
	localparam int MUL_B_W    = 18;
	localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
	localparam int NUM_W      = 52;
	localparam int DEN_W      = 35;
	localparam int QUO_W      = 17;
	localparam int CNT_W      = 5;

	localparam logic signed [MUL_B_W-1:0] K_SQRT3_2   = 18'sd56756;
	localparam logic signed [MUL_B_W-1:0] K_INV_SQRT3 = 18'sd37837;
	localparam logic [V_W-1:0]            Q30_ONE     = 33'd1073741824;
	localparam logic [49:0]               Q30_HALF    = 50'd536870912;

	localparam logic [1:0] CFG_PERIOD    = 2'd0;
	localparam logic [1:0] CFG_MIN_PULSE = 2'd1;
	localparam logic [1:0] CFG_GAIN      = 2'd2;

	localparam logic [COUNT_BITS-1:0] PERIOD_RST    = COUNT_BITS'(2000);
	localparam logic [14:0]           MIN_PULSE_RST = 15'd8;
	localparam logic [15:0]           GAIN_RST      = 16'd6554;

	typedef struct packed {
		logic [COUNT_BITS-1:0] period;
		logic [14:0]           min_pulse;
		logic [15:0]           gain;
	} svpwm_cfg_t;

	typedef struct packed {
		logic [V_W-1:0]     v_a;
		logic [V_W-1:0]     v_b;
		logic [V_W-1:0]     v_c;
		logic [V_W-1:0]     span;
		logic               scale;
		logic signed [15:0] rcos;
		logic signed [15:0] rsin;
		logic [15:0]        sup;
	} svpwm_item_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CNT_MUL,
		S_CNT_DIV,
		S_CNT_WAIT,
		S_CNT_SNAP,
		S_VA_MUL,
		S_VA_DIV,
		S_VA_WAIT,
		S_VB_MUL1,
		S_VB_MUL2,
		S_VB_DIV,
		S_VB_WAIT,
		S_UD_M1,
		S_UD_M2,
		S_UQ_M1,
		S_UQ_M2,
		S_FD,
		S_FQ,
		S_FQ2,
		S_DONE
	} svpwm_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7FFFFFFF;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

/* hw/rtl/svpwm_front.sv */
module svpwm_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [79:0]           in_data,
	output logic                  push,
	input  logic                  fifo_full,
	output svpwm_pkg::svpwm_item_t item
);

	logic                                 s1_valid_q;
	logic signed [svpwm_pkg::PH_W-1:0]    pa_s1, pb_s1, pc_s1;
	logic signed [15:0]                   rcos_s1, rsin_s1;
	logic [15:0]                          sup_s1;
	logic signed [15:0]                   x, y;
	logic signed [svpwm_pkg::PH_W-1:0]    x_half, y_k;
	logic signed [svpwm_pkg::PH_W-1:0]    mn, mx, span_w;

	assign x      = in_data[15:0];
	assign y      = in_data[31:16];
	assign x_half = svpwm_pkg::PH_W'(x) <<< 15;
	assign y_k    = svpwm_pkg::PH_W'(y) * svpwm_pkg::PH_W'(svpwm_pkg::K_SQRT3_2);

	assign in_ready = !s1_valid_q || !fifo_full;
	assign push     = s1_valid_q && !fifo_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pa_s1   <= svpwm_pkg::PH_W'(x) <<< 16;
			pb_s1   <= y_k - x_half;
			pc_s1   <= -x_half - y_k;
			rcos_s1 <= in_data[47:32];
			rsin_s1 <= in_data[63:48];
			sup_s1  <= in_data[79:64];
		end
	end

	always_comb begin
		mn = (pa_s1 < pb_s1) ? pa_s1 : pb_s1;
		mx = (pa_s1 < pb_s1) ? pb_s1 : pa_s1;
		if (pc_s1 < mn) begin
			mn = pc_s1;
		end
		if (pc_s1 > mx) begin
			mx = pc_s1;
		end
		span_w = mx - mn;
	end

	always_comb begin
		item.v_a   = svpwm_pkg::V_W'(pa_s1 - mn);
		item.v_b   = svpwm_pkg::V_W'(pb_s1 - mn);
		item.v_c   = svpwm_pkg::V_W'(pc_s1 - mn);
		item.span  = svpwm_pkg::V_W'(span_w);
		item.scale = svpwm_pkg::V_W'(span_w) > svpwm_pkg::Q30_ONE;
		item.rcos  = rcos_s1;
		item.rsin  = rsin_s1;
		item.sup   = sup_s1;
	end

endmodule

/* hw/rtl/svpwm_fifo.sv */
module svpwm_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  svpwm_pkg::svpwm_item_t wr_item,
	output logic                  full,
	input  logic                  pop,
	output logic                  valid,
	output svpwm_pkg::svpwm_item_t rd_item
);

	svpwm_pkg::svpwm_item_t mem_q [2];
	logic                   wr_ptr_q, rd_ptr_q;
	logic [1:0]             count_q;

	assign full    = count_q == 2'd2;
	assign valid   = count_q != 2'd0;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> valid)
		else $error("queue underflow");

endmodule

/* hw/rtl/svpwm_div.sv */
module svpwm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [svpwm_pkg::NUM_W-1:0] num,
	input  logic [svpwm_pkg::DEN_W-1:0] den,
	output logic                        busy,
	output logic                        done,
	output logic [svpwm_pkg::QUO_W-1:0] quot
);

	logic [svpwm_pkg::NUM_W-1:0] rem_q, den_q;
	logic [svpwm_pkg::NUM_W:0]   trial;
	logic [svpwm_pkg::CNT_W-1:0] cnt_q;
	logic                        busy_q, done_q;
	logic [svpwm_pkg::QUO_W-1:0] quot_q;

	assign trial = {1'b0, rem_q} - {1'b0, den_q};
	assign busy  = busy_q;
	assign done  = done_q;
	assign quot  = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= svpwm_pkg::CNT_W'(svpwm_pkg::QUO_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= svpwm_pkg::NUM_W'({den, (svpwm_pkg::QUO_W - 1)'(0)});
			quot_q <= '0;
		end else if (busy_q) begin
			den_q <= den_q >> 1;
			if (!trial[svpwm_pkg::NUM_W]) begin
				rem_q  <= trial[svpwm_pkg::NUM_W-1:0];
				quot_q <= {quot_q[svpwm_pkg::QUO_W-2:0], 1'b1};
			end else begin
				quot_q <= {quot_q[svpwm_pkg::QUO_W-2:0], 1'b0};
			end
		end
	end

endmodule

/* hw/rtl/svpwm_back.sv */
module svpwm_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  svpwm_pkg::svpwm_cfg_t  cfg,
	input  logic                   item_valid,
	input  svpwm_pkg::svpwm_item_t item,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [111:0]           out_data
);

	svpwm_pkg::svpwm_state_t state_q, state_d;
	svpwm_pkg::svpwm_item_t  item_q;
	logic [1:0]              ph_q;
	logic [15:0]             duty_q [3];
	logic [svpwm_pkg::QUO_W-1:0] d_q;
	logic signed [svpwm_pkg::MUL_P_W-1:0] mul_q, mul_p;
	logic signed [svpwm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [svpwm_pkg::MUL_B_W-1:0] mul_b;
	logic [svpwm_pkg::MUL_P_W-1:0]        abs_mul;
	logic                    neg_q;
	logic signed [15:0]      va_q, vb_q, vsat;
	logic signed [31:0]      p1_q, ud_q, uq_q, acc_d_q, acc_q_q;
	logic                    out_valid_q;
	logic [111:0]            out_data_q;
	logic [svpwm_pkg::V_W-1:0] v_sel;
	logic signed [18:0]      n_va;
	logic signed [17:0]      n_vb;
	logic [17:0]             per3;
	logic                    div_start, div_busy, div_done, out_load;
	logic [svpwm_pkg::NUM_W-1:0] div_num;
	logic [svpwm_pkg::DEN_W-1:0] div_den;
	logic [svpwm_pkg::QUO_W-1:0] div_quot;

	svpwm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		unique case (ph_q)
			2'd0:    v_sel = item_q.v_a;
			2'd1:    v_sel = item_q.v_b;
			default: v_sel = item_q.v_c;
		endcase
	end

	assign n_va    = $signed({2'b0, duty_q[0], 1'b0}) - $signed({3'b0, duty_q[1]})
		- $signed({3'b0, duty_q[2]});
	assign n_vb    = $signed({2'b0, duty_q[1]}) - $signed({2'b0, duty_q[2]});
	assign per3    = {1'b0, cfg.period, 1'b0} + {2'b0, cfg.period};
	assign mul_p   = mul_a * mul_b;
	assign abs_mul = mul_q[svpwm_pkg::MUL_P_W-1] ? svpwm_pkg::MUL_P_W'(-mul_q) : mul_q;

	always_comb begin
		if (!neg_q) begin
			vsat = (div_quot > 17'd32767) ? 16'sh7FFF : $signed(div_quot[15:0]);
		end else begin
			vsat = (div_quot > 17'd32768) ? 16'sh8000 : 16'(-$signed({1'b0, div_quot}));
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			svpwm_pkg::S_IDLE:     if (item_valid) state_d = svpwm_pkg::S_CNT_MUL;
			svpwm_pkg::S_CNT_MUL:  state_d = svpwm_pkg::S_CNT_DIV;
			svpwm_pkg::S_CNT_DIV:  state_d = item_q.scale ? svpwm_pkg::S_CNT_WAIT
				: svpwm_pkg::S_CNT_SNAP;
			svpwm_pkg::S_CNT_WAIT: if (div_done) state_d = svpwm_pkg::S_CNT_SNAP;
			svpwm_pkg::S_CNT_SNAP: state_d = (ph_q == 2'd2) ? svpwm_pkg::S_VA_MUL
				: svpwm_pkg::S_CNT_MUL;
			svpwm_pkg::S_VA_MUL:   state_d = (cfg.period == '0) ? svpwm_pkg::S_UD_M1
				: svpwm_pkg::S_VA_DIV;
			svpwm_pkg::S_VA_DIV:   state_d = svpwm_pkg::S_VA_WAIT;
			svpwm_pkg::S_VA_WAIT:  if (div_done) state_d = svpwm_pkg::S_VB_MUL1;
			svpwm_pkg::S_VB_MUL1:  state_d = svpwm_pkg::S_VB_MUL2;
			svpwm_pkg::S_VB_MUL2:  state_d = svpwm_pkg::S_VB_DIV;
			svpwm_pkg::S_VB_DIV:   state_d = svpwm_pkg::S_VB_WAIT;
			svpwm_pkg::S_VB_WAIT:  if (div_done) state_d = svpwm_pkg::S_UD_M1;
			svpwm_pkg::S_UD_M1:    state_d = svpwm_pkg::S_UD_M2;
			svpwm_pkg::S_UD_M2:    state_d = svpwm_pkg::S_UQ_M1;
			svpwm_pkg::S_UQ_M1:    state_d = svpwm_pkg::S_UQ_M2;
			svpwm_pkg::S_UQ_M2:    state_d = svpwm_pkg::S_FD;
			svpwm_pkg::S_FD:       state_d = svpwm_pkg::S_FQ;
			svpwm_pkg::S_FQ:       state_d = svpwm_pkg::S_FQ2;
			svpwm_pkg::S_FQ2:      state_d = svpwm_pkg::S_DONE;
			svpwm_pkg::S_DONE:     if (!out_valid_q || out_ready) state_d = svpwm_pkg::S_IDLE;
			default:               state_d = svpwm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		pop       = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			svpwm_pkg::S_IDLE: pop = item_valid;
			svpwm_pkg::S_CNT_MUL: begin
				mul_a = $signed({2'b0, v_sel});
				mul_b = $signed({2'b0, cfg.period});
			end
			svpwm_pkg::S_CNT_DIV: begin
				div_start = item_q.scale;
				div_num   = svpwm_pkg::NUM_W'({mul_q[49:0], 1'b0})
					+ svpwm_pkg::NUM_W'(item_q.span);
				div_den   = svpwm_pkg::DEN_W'({item_q.span, 1'b0});
			end
			svpwm_pkg::S_VA_MUL: begin
				mul_a = svpwm_pkg::MUL_A_W'(n_va);
				mul_b = $signed({2'b0, item_q.sup});
			end
			svpwm_pkg::S_VA_DIV: begin
				div_start = 1'b1;
				div_num   = svpwm_pkg::NUM_W'({abs_mul[49:0], 1'b0})
					+ svpwm_pkg::NUM_W'(per3);
				div_den   = svpwm_pkg::DEN_W'({per3, 1'b0});
			end
			svpwm_pkg::S_VB_MUL1: begin
				mul_a = svpwm_pkg::MUL_A_W'(n_vb);
				mul_b = $signed({2'b0, item_q.sup});
			end
			svpwm_pkg::S_VB_MUL2: begin
				mul_a = mul_q[svpwm_pkg::MUL_A_W-1:0];
				mul_b = svpwm_pkg::K_INV_SQRT3;
			end
			svpwm_pkg::S_VB_DIV: begin
				div_start = 1'b1;
				div_num   = svpwm_pkg::NUM_W'({abs_mul[49:0], 1'b0})
					+ svpwm_pkg::NUM_W'({cfg.period, 16'b0});
				div_den   = svpwm_pkg::DEN_W'({cfg.period, 17'b0});
			end
			svpwm_pkg::S_UD_M1: begin
				mul_a = svpwm_pkg::MUL_A_W'(item_q.rcos);
				mul_b = svpwm_pkg::MUL_B_W'(va_q);
			end
			svpwm_pkg::S_UD_M2: begin
				mul_a = svpwm_pkg::MUL_A_W'(item_q.rsin);
				mul_b = svpwm_pkg::MUL_B_W'(vb_q);
			end
			svpwm_pkg::S_UQ_M1: begin
				mul_a = svpwm_pkg::MUL_A_W'(item_q.rcos);
				mul_b = svpwm_pkg::MUL_B_W'(vb_q);
			end
			svpwm_pkg::S_UQ_M2: begin
				mul_a = svpwm_pkg::MUL_A_W'(item_q.rsin);
				mul_b = svpwm_pkg::MUL_B_W'(va_q);
			end
			svpwm_pkg::S_FD: begin
				mul_a = svpwm_pkg::MUL_A_W'(ud_q) - svpwm_pkg::MUL_A_W'(acc_d_q);
				mul_b = $signed({2'b0, cfg.gain});
			end
			svpwm_pkg::S_FQ: begin
				mul_a = svpwm_pkg::MUL_A_W'(uq_q) - svpwm_pkg::MUL_A_W'(acc_q_q);
				mul_b = $signed({2'b0, cfg.gain});
			end
			svpwm_pkg::S_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= svpwm_pkg::S_IDLE;
			ph_q        <= 2'd0;
			acc_d_q     <= '0;
			acc_q_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				ph_q <= 2'd0;
			end else if (state_q == svpwm_pkg::S_CNT_SNAP) begin
				ph_q <= ph_q + 2'd1;
			end
			if (state_q == svpwm_pkg::S_FQ) begin
				acc_d_q <= acc_d_q + 32'(mul_q >>> 16);
			end
			if (state_q == svpwm_pkg::S_FQ2) begin
				acc_q_q <= acc_q_q + 32'(mul_q >>> 16);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (pop) begin
			item_q <= item;
		end
		unique case (state_q)
			svpwm_pkg::S_CNT_DIV: d_q <= svpwm_pkg::QUO_W'((mul_q[49:0] + svpwm_pkg::Q30_HALF) >> 30);
			svpwm_pkg::S_CNT_WAIT: if (div_done) d_q <= div_quot;
			svpwm_pkg::S_CNT_SNAP: begin
				if ({1'b0, d_q} < {3'b0, cfg.min_pulse}) begin
					duty_q[ph_q] <= '0;
				end else if ({1'b0, d_q} + {3'b0, cfg.min_pulse} > {2'b0, cfg.period}) begin
					duty_q[ph_q] <= cfg.period;
				end else begin
					duty_q[ph_q] <= d_q[15:0];
				end
			end
			svpwm_pkg::S_VA_MUL: begin
				va_q <= '0;
				vb_q <= '0;
			end
			svpwm_pkg::S_VA_DIV, svpwm_pkg::S_VB_DIV: neg_q <= mul_q[svpwm_pkg::MUL_P_W-1];
			svpwm_pkg::S_VA_WAIT: if (div_done) va_q <= vsat;
			svpwm_pkg::S_VB_WAIT: if (div_done) vb_q <= vsat;
			svpwm_pkg::S_UD_M2, svpwm_pkg::S_UQ_M2: p1_q <= mul_q[31:0];
			svpwm_pkg::S_UQ_M1: ud_q <= svpwm_pkg::sat32(
				(35'(p1_q) + 35'($signed(mul_q[31:0]))) <<< 1);
			svpwm_pkg::S_FD: uq_q <= svpwm_pkg::sat32(
				(35'(p1_q) - 35'($signed(mul_q[31:0]))) <<< 1);
			default: ;
		endcase
		if (out_load) begin
			out_data_q <= {acc_q_q[31:16], acc_d_q[31:16], vb_q, va_q,
				duty_q[2], duty_q[1], duty_q[0]};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_div_free: assert property (@(posedge clk) disable iff (!arst_n) div_start |-> !div_busy)
		else $error("divider restarted while busy");
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == svpwm_pkg::S_DONE && !out_valid_q) |=> out_valid_q)
		else $error("finished item not loaded");

endmodule

/* hw/rtl/space_vector_pwm_modulator_top.sv */
// Space-vector PWM modulator that shifts the lowest phase to zero, with D/Q voltage filter.
// Input channel s_*: one item per PWM period (alpha/beta command, rotor cos/sin,
// supply volts). Output channel m_*: one result item per input item, in order,
// carrying three compare counts, rebuilt alpha/beta volts and filtered D/Q volts.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 period,
// 1 minimum pulse, 2 filter gain); write only while no item is in flight.
// An item is registered in the front stage, then the back sequencer runs one
// shared multiplier and a radix-2 divider producing 17 quotient bits, one per
// cycle. The three phases need three extra divisions only when the phase span
// exceeds one and they are scaled; the two volt divisions are skipped for a
// zero period. Throughput is one item per back-end pass; a two-entry queue
// lets the front accept while the back works.
// Reset clears the filter accumulators, the queue and the output valid flag and
// restores period 2000, minimum pulse 8 and gain 6554.
// A stalled receiver holds the result in the output register; the back then
// waits, and the front stops accepting once the queue and its stage register are full.
module space_vector_pwm_modulator_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [79:0]  s_tdata,   // alpha_cmd, beta_cmd, rotor_cos, rotor_sin, supply_volts
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [111:0] m_tdata,   // duty_a, duty_b, duty_c, volt_alpha, volt_beta, filt_d, filt_q
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	svpwm_pkg::svpwm_cfg_t  cfg_q;
	svpwm_pkg::svpwm_item_t front_item, queue_item;
	logic                   push, full, pop, queue_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period    <= svpwm_pkg::PERIOD_RST;
			cfg_q.min_pulse <= svpwm_pkg::MIN_PULSE_RST;
			cfg_q.gain      <= svpwm_pkg::GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svpwm_pkg::CFG_PERIOD:    cfg_q.period    <= cfg_data[svpwm_pkg::COUNT_BITS-1:0];
				svpwm_pkg::CFG_MIN_PULSE: cfg_q.min_pulse <= cfg_data[14:0];
				svpwm_pkg::CFG_GAIN:      cfg_q.gain      <= cfg_data;
				default: ;
			endcase
		end
	end

	svpwm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (s_tdata),
		.push      (push),
		.fifo_full (full),
		.item      (front_item)
	);

	svpwm_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_item),
		.full    (full),
		.pop     (pop),
		.valid   (queue_valid),
		.rd_item (queue_item)
	);

	svpwm_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (queue_valid),
		.item       (queue_item),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata)
	);

endmodule
